// ===== hw/rtl/bss_pkg.sv =====
// Shared types, codes and constants of the boid steering step block.
`default_nettype none
package bss_pkg;
	localparam int POS_W      = 32;
	localparam int IDX_W      = 10;
	localparam int DIST_W     = 31;
	localparam int GAIN_W     = 16;
	localparam int CNT_W      = 11;
	localparam int AVOID_W    = 42;
	localparam int D_W        = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [1:0] OP_START  = 2'd0;
	localparam logic [1:0] OP_FLOCK  = 2'd1;
	localparam logic [1:0] OP_TARGET = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VIEW_RADIUS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_GAIN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MATCH_GAIN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_AVOID_GAIN   = 3'd4;

	localparam logic [DIST_W-1:0] RST_MIN_DISTANCE = 31'd524288;
	localparam logic [DIST_W-1:0] RST_VIEW_RADIUS  = 31'd2621440;
	localparam logic [GAIN_W-1:0] RST_CENTER_GAIN  = 16'd33;
	localparam logic [GAIN_W-1:0] RST_MATCH_GAIN   = 16'd3277;
	localparam logic [GAIN_W-1:0] RST_AVOID_GAIN   = 16'd3277;

	localparam logic signed [AVOID_W-1:0] AVOID_MAX = 42'sh1FF_FFFF_FFFF;
	localparam logic signed [AVOID_W-1:0] AVOID_MIN = 42'sh200_0000_0000;
	localparam logic signed [D_W-1:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [D_W-1:0] SAT_LO = 64'shFFFF_FFFF_8000_0000;

	typedef enum logic [1:0] {
		K_START,
		K_FLOCK,
		K_TARGET,
		K_NONE
	} kind_t;

	typedef struct packed {
		kind_t                    kind;
		logic [IDX_W-1:0]         idx;
		logic signed [POS_W-1:0]  px;
		logic signed [POS_W-1:0]  py;
		logic signed [POS_W-1:0]  qx;
		logic signed [POS_W-1:0]  qy;
		logic                     last;
	} item_t;

	typedef struct packed {
		logic [DIST_W-1:0] min_distance;
		logic [DIST_W-1:0] view_radius;
		logic [GAIN_W-1:0] center_gain;
		logic [GAIN_W-1:0] match_gain;
		logic [GAIN_W-1:0] avoid_gain;
	} cfg_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_DECODE,
		BK_DIFF,
		BK_SQ,
		BK_CMP,
		BK_ACC,
		BK_FIN,
		BK_PHASE,
		BK_DIV_GO,
		BK_DIV_WAIT,
		BK_MUL_GO,
		BK_MUL_WAIT,
		BK_AXIS_END,
		BK_OUT
	} back_state_t;

	typedef enum logic [1:0] {
		PH_COH,
		PH_ALN,
		PH_REP,
		PH_AVD
	} phase_t;
endpackage
`default_nettype wire

// ===== hw/rtl/bss_front.sv =====
// Front end: takes input words, classifies the operation, feeds the queue.
`default_nettype none
module bss_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         operation,
	input  logic [bss_pkg::IDX_W-1:0]          member_index,
	input  logic signed [bss_pkg::POS_W-1:0]   pos_x,
	input  logic signed [bss_pkg::POS_W-1:0]   pos_y,
	input  logic signed [bss_pkg::POS_W-1:0]   dir_x,
	input  logic signed [bss_pkg::POS_W-1:0]   dir_y,
	input  logic                               last,
	output logic                               push,
	output bss_pkg::item_t                     push_item,
	input  logic                               q_full
);
	import bss_pkg::*;

	logic  vld_s1;
	item_t item_s1;
	kind_t kind;
	logic  take;

	always_comb begin
		case (operation)
			OP_START:  kind = K_START;
			OP_FLOCK:  kind = K_FLOCK;
			OP_TARGET: kind = K_TARGET;
			default:   kind = K_NONE;
		endcase
	end

	assign in_stall  = vld_s1 & q_full;
	assign take      = in_valid & ~in_stall;
	assign push      = vld_s1 & ~q_full;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.kind <= kind;
			item_s1.idx  <= member_index;
			item_s1.px   <= pos_x;
			item_s1.py   <= pos_y;
			item_s1.qx   <= dir_x;
			item_s1.qy   <= dir_y;
			item_s1.last <= last;
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/bss_queue.sv =====
// Short item queue between the front end and the back end.
`default_nettype none
module bss_queue #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bss_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output bss_pkg::item_t head
);
	import bss_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t         mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/bss_div.sv =====
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating.
`default_nettype none
module bss_div #(
	parameter int DW = 42,
	parameter int VW = 11
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [DW-1:0] dividend,
	input  logic [VW-1:0]        divisor,
	output logic                 done,
	output logic signed [DW-1:0] quotient
);
	localparam int CNTW = $clog2(DW + 1);

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [DW-1:0]   mag_q;
	logic [VW:0]     rem_q;
	logic            neg_q;
	logic [VW:0]     rem_sh;
	logic            ge;

	assign rem_sh   = {rem_q[VW-1:0], mag_q[DW-1]};
	assign ge       = (rem_sh >= {1'b0, divisor});
	assign done     = done_q;
	assign quotient = neg_q ? -$signed(mag_q) : $signed(mag_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
			neg_q <= dividend[DW-1];
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sh - {1'b0, divisor} : rem_sh;
			mag_q <= {mag_q[DW-2:0], ge};
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/bss_mul.sv =====
// Serial shift-add multiplier of a signed operand by an unsigned gain.
`default_nettype none
module bss_mul #(
	parameter int AW = 64,
	parameter int BW = 17
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [AW-1:0] a,
	input  logic [BW-1:0]        b,
	output logic                 done,
	output logic signed [AW-1:0] product
);
	localparam int CNTW = $clog2(BW + 1);

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [AW-1:0]   a_q;
	logic [BW-1:0]   b_q;
	logic [AW-1:0]   acc_q;

	assign done    = done_q;
	assign product = $signed(acc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(BW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= {a_q[AW-2:0], 1'b0};
			b_q <= {1'b0, b_q[BW-1:1]};
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/bss_back.sv =====
// Back end: distance tests, accumulation and the steering sequencer.
`default_nettype none
module bss_back #(
	parameter int MAX_FLOCK = 1024,
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	input  bss_pkg::item_t                    q_item,
	output logic                              pop,
	input  bss_pkg::cfg_t                     cfg,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [bss_pkg::POS_W-1:0]  new_dir_x,
	output logic signed [bss_pkg::POS_W-1:0]  new_dir_y,
	output logic [bss_pkg::CNT_W-1:0]         near_count,
	output logic [bss_pkg::CNT_W-1:0]         target_count
);
	import bss_pkg::*;

	localparam int TALLY_W = $clog2(MAX_FLOCK + 1);
	localparam int SUM_W   = POS_W + $clog2(MAX_FLOCK);
	localparam int SQ_W    = 2 * DIST_W;
	localparam int MG_W    = GAIN_W + 1;
	localparam int AS_W    = AVOID_W + 1;

	back_state_t state_q, state_d;
	item_t       cur_q;

	logic signed [POS_W-1:0]   own_x_q, own_y_q, own_dx_q, own_dy_q;
	logic [IDX_W-1:0]          own_idx_q;
	logic signed [SUM_W-1:0]   spx_q, spy_q, sdx_q, sdy_q, tx_q, ty_q;
	logic signed [AVOID_W-1:0] avx_q, avy_q;
	logic [TALLY_W-1:0]        near_q, tgt_q;

	logic signed [POS_W:0]     dx_q, dy_q;
	logic [POS_W-1:0]          ax_q, ay_q;
	logic [1:0]                sq_step_q;
	logic [SQ_W-1:0]           sqx_q, sqy_q, mt2_q, vt2_q;
	logic                      in_min_q, in_view_q;

	logic                      axis_q;
	phase_t                    phase_q;
	logic signed [D_W-1:0]     d_q, mean_q;
	logic signed [POS_W-1:0]   res_x_q, res_y_q;

	logic                      out_valid_q;
	logic signed [POS_W-1:0]   out_x_q, out_y_q;
	logic [CNT_W-1:0]          out_near_q, out_tgt_q;

	logic signed [POS_W:0]     dx_c, dy_c;
	logic [DIST_W-1:0]         sq_op;
	logic [SQ_W-1:0]           sq_prod;
	logic [SQ_W:0]             sq_sum;
	logic                      min_c, view_c;
	logic signed [AS_W-1:0]    avx_sum, avy_sum;
	logic signed [AVOID_W-1:0] avx_sat, avy_sat;

	logic                      div_start, div_done;
	logic signed [SUM_W-1:0]   div_num, div_quo;
	logic [TALLY_W-1:0]        div_den;
	logic                      mul_start, mul_done;
	logic signed [D_W-1:0]     mul_a, mul_prod, shifted, own_pos, d_sat_src;
	logic [MG_W-1:0]           mul_b;
	phase_t                    entry_phase, phase_next;
	logic signed [POS_W-1:0]   d_sat;
	logic                      out_load;

	assign dx_c = $signed({own_x_q[POS_W-1], own_x_q}) - $signed({cur_q.px[POS_W-1], cur_q.px});
	assign dy_c = $signed({own_y_q[POS_W-1], own_y_q}) - $signed({cur_q.py[POS_W-1], cur_q.py});

	always_comb begin
		case (sq_step_q)
			2'd0:    sq_op = ax_q[DIST_W-1:0];
			2'd1:    sq_op = ay_q[DIST_W-1:0];
			2'd2:    sq_op = cfg.min_distance;
			default: sq_op = cfg.view_radius;
		endcase
	end
	assign sq_prod = sq_op * sq_op;
	assign sq_sum  = {1'b0, sqx_q} + {1'b0, sqy_q};
	assign min_c   = (ax_q < {1'b0, cfg.min_distance}) && (ay_q < {1'b0, cfg.min_distance})
		&& (sq_sum < {1'b0, mt2_q});
	assign view_c  = (ax_q < {1'b0, cfg.view_radius}) && (ay_q < {1'b0, cfg.view_radius})
		&& (sq_sum < {1'b0, vt2_q});

	assign avx_sum = AS_W'(avx_q) + AS_W'(dx_q);
	assign avy_sum = AS_W'(avy_q) + AS_W'(dy_q);
	assign avx_sat = (avx_sum[AS_W-1] != avx_sum[AS_W-2])
		? (avx_sum[AS_W-1] ? AVOID_MIN : AVOID_MAX) : avx_sum[AVOID_W-1:0];
	assign avy_sat = (avy_sum[AS_W-1] != avy_sum[AS_W-2])
		? (avy_sum[AS_W-1] ? AVOID_MIN : AVOID_MAX) : avy_sum[AVOID_W-1:0];

	assign own_pos = axis_q ? D_W'(own_y_q) : D_W'(own_x_q);

	always_comb begin
		case (phase_q)
			PH_COH: begin
				div_num = axis_q ? spy_q : spx_q;
				div_den = near_q;
				mul_a   = mean_q - own_pos;
				mul_b   = {1'b0, cfg.center_gain};
			end
			PH_ALN: begin
				div_num = axis_q ? sdy_q : sdx_q;
				div_den = near_q;
				mul_a   = mean_q - d_q;
				mul_b   = {1'b0, cfg.match_gain};
			end
			PH_REP: begin
				div_num = axis_q ? ty_q : tx_q;
				div_den = tgt_q;
				mul_a   = mean_q - own_pos;
				mul_b   = {cfg.center_gain, 1'b0};
			end
			default: begin
				div_num = axis_q ? ty_q : tx_q;
				div_den = tgt_q;
				mul_a   = axis_q ? D_W'(avy_q) : D_W'(avx_q);
				mul_b   = {1'b0, cfg.avoid_gain};
			end
		endcase
	end

	assign shifted = mul_prod >>> FRAC_BITS;

	always_comb begin
		if (near_q != '0) begin
			entry_phase = PH_COH;
		end else if (tgt_q != '0) begin
			entry_phase = PH_REP;
		end else begin
			entry_phase = PH_AVD;
		end
		case (phase_q)
			PH_COH:  phase_next = PH_ALN;
			PH_ALN:  phase_next = (tgt_q != '0) ? PH_REP : PH_AVD;
			default: phase_next = PH_AVD;
		endcase
	end

	assign d_sat_src = d_q;
	assign d_sat = (d_sat_src > SAT_HI) ? SAT_HI[POS_W-1:0]
		: (d_sat_src < SAT_LO) ? SAT_LO[POS_W-1:0] : d_sat_src[POS_W-1:0];

	bss_div #(.DW(SUM_W), .VW(TALLY_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_quo)
	);

	bss_mul #(.AW(D_W), .BW(MG_W)) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.done    (mul_done),
		.product (mul_prod)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					state_d = BK_DECODE;
				end
			end
			BK_DECODE: begin
				case (cur_q.kind)
					K_FLOCK:  state_d = (cur_q.idx != own_idx_q) ? BK_DIFF
						: (cur_q.last ? BK_FIN : BK_IDLE);
					K_TARGET: state_d = BK_DIFF;
					default:  state_d = cur_q.last ? BK_FIN : BK_IDLE;
				endcase
			end
			BK_DIFF:     state_d = BK_SQ;
			BK_SQ:       state_d = (sq_step_q == 2'd3) ? BK_CMP : BK_SQ;
			BK_CMP:      state_d = BK_ACC;
			BK_ACC:      state_d = cur_q.last ? BK_FIN : BK_IDLE;
			BK_FIN:      state_d = BK_PHASE;
			BK_PHASE:    state_d = (phase_q == PH_AVD) ? BK_MUL_GO : BK_DIV_GO;
			BK_DIV_GO:   state_d = BK_DIV_WAIT;
			BK_DIV_WAIT: state_d = div_done ? BK_MUL_GO : BK_DIV_WAIT;
			BK_MUL_GO:   state_d = BK_MUL_WAIT;
			BK_MUL_WAIT: begin
				if (mul_done) begin
					state_d = (phase_q == PH_AVD) ? BK_AXIS_END : BK_PHASE;
				end
			end
			BK_AXIS_END: state_d = axis_q ? BK_OUT : BK_FIN;
			BK_OUT:      state_d = (!out_valid_q || !out_stall) ? BK_IDLE : BK_OUT;
			default:     state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		div_start = 1'b0;
		mul_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			BK_IDLE:   pop       = q_valid;
			BK_DIV_GO: div_start = 1'b1;
			BK_MUL_GO: mul_start = 1'b1;
			BK_OUT:    out_load  = !out_valid_q || !out_stall;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			own_x_q     <= '0;
			own_y_q     <= '0;
			own_dx_q    <= '0;
			own_dy_q    <= '0;
			own_idx_q   <= '0;
			spx_q       <= '0;
			spy_q       <= '0;
			sdx_q       <= '0;
			sdy_q       <= '0;
			tx_q        <= '0;
			ty_q        <= '0;
			avx_q       <= '0;
			avy_q       <= '0;
			near_q      <= '0;
			tgt_q       <= '0;
			sq_step_q   <= '0;
			axis_q      <= 1'b0;
			phase_q     <= PH_AVD;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				BK_DECODE: begin
					if (cur_q.kind == K_START) begin
						own_x_q   <= cur_q.px;
						own_y_q   <= cur_q.py;
						own_dx_q  <= cur_q.qx;
						own_dy_q  <= cur_q.qy;
						own_idx_q <= cur_q.idx;
						spx_q     <= '0;
						spy_q     <= '0;
						sdx_q     <= '0;
						sdy_q     <= '0;
						tx_q      <= '0;
						ty_q      <= '0;
						avx_q     <= '0;
						avy_q     <= '0;
						near_q    <= '0;
						tgt_q     <= '0;
					end
				end
				BK_DIFF: sq_step_q <= '0;
				BK_SQ:   sq_step_q <= sq_step_q + 1'b1;
				BK_ACC: begin
					if (cur_q.kind == K_FLOCK) begin
						if (in_min_q) begin
							avx_q <= avx_sat;
							avy_q <= avy_sat;
						end
						if (in_view_q && near_q < TALLY_W'(MAX_FLOCK)) begin
							spx_q  <= spx_q + SUM_W'(cur_q.px);
							spy_q  <= spy_q + SUM_W'(cur_q.py);
							sdx_q  <= sdx_q + SUM_W'(cur_q.qx);
							sdy_q  <= sdy_q + SUM_W'(cur_q.qy);
							near_q <= near_q + 1'b1;
						end
					end else if (in_view_q && tgt_q < TALLY_W'(MAX_FLOCK)) begin
						tx_q  <= tx_q + SUM_W'(cur_q.px);
						ty_q  <= ty_q + SUM_W'(cur_q.py);
						tgt_q <= tgt_q + 1'b1;
					end
				end
				BK_FIN: phase_q <= entry_phase;
				BK_MUL_WAIT: begin
					if (mul_done) begin
						phase_q <= phase_next;
					end
				end
				BK_AXIS_END: axis_q <= ~axis_q;
				BK_OUT: begin
					if (out_load) begin
						own_dx_q <= res_x_q;
						own_dy_q <= res_y_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_item;
		end
		case (state_q)
			BK_DIFF: begin
				dx_q <= dx_c;
				dy_q <= dy_c;
				ax_q <= dx_c[POS_W] ? POS_W'(-dx_c) : dx_c[POS_W-1:0];
				ay_q <= dy_c[POS_W] ? POS_W'(-dy_c) : dy_c[POS_W-1:0];
			end
			BK_SQ: begin
				case (sq_step_q)
					2'd0:    sqx_q <= sq_prod;
					2'd1:    sqy_q <= sq_prod;
					2'd2:    mt2_q <= sq_prod;
					default: vt2_q <= sq_prod;
				endcase
			end
			BK_CMP: begin
				in_min_q  <= min_c;
				in_view_q <= view_c;
			end
			BK_FIN: d_q <= axis_q ? D_W'(own_dy_q) : D_W'(own_dx_q);
			BK_DIV_WAIT: begin
				if (div_done) begin
					mean_q <= D_W'(div_quo);
				end
			end
			BK_MUL_WAIT: begin
				if (mul_done) begin
					d_q <= (phase_q == PH_REP) ? d_q - shifted : d_q + shifted;
				end
			end
			BK_AXIS_END: begin
				if (axis_q) begin
					res_y_q <= d_sat;
				end else begin
					res_x_q <= d_sat;
				end
			end
			BK_OUT: begin
				if (out_load) begin
					out_x_q    <= res_x_q;
					out_y_q    <= res_y_q;
					out_near_q <= CNT_W'(near_q);
					out_tgt_q  <= CNT_W'(tgt_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign new_dir_x    = out_x_q;
	assign new_dir_y    = out_y_q;
	assign near_count   = out_near_q;
	assign target_count = out_tgt_q;
endmodule
`default_nettype wire

// ===== hw/rtl/boid_steering_step_top.sv =====
// Top level of the boid steering step block: config registers, front, queue, back.
`default_nettype none
// Computes one boid's new heading from a stream of words: a start word with the
// own boid, then flock and target words, the one marked last releasing the
// result. The front end takes a word per cycle, while the queue has room, into
// a two-entry queue; the back end works one word at a time. A flock or target
// word goes through the decode, difference, square, compare and accumulate
// states, with the one squaring multiplier shared over the four squares of
// the distance test; start and skipped words leave from decode. A last word
// adds the steering pass: per axis up to three divisions (one quotient bit per
// cycle) and up to four serial gain multiplies. The result sits in an output
// register, so later words keep flowing while it waits to be taken, until the
// next result must be loaded. Configuration writes are taken at any time and must land while idle.
module boid_steering_step_top #(
	parameter int MAX_FLOCK = 1024,
	parameter int FRAC_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          operation,
	input  logic [bss_pkg::IDX_W-1:0]           member_index,
	input  logic signed [bss_pkg::POS_W-1:0]    pos_x,
	input  logic signed [bss_pkg::POS_W-1:0]    pos_y,
	input  logic signed [bss_pkg::POS_W-1:0]    dir_x,
	input  logic signed [bss_pkg::POS_W-1:0]    dir_y,
	input  logic                                last,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [bss_pkg::POS_W-1:0]    new_dir_x,
	output logic signed [bss_pkg::POS_W-1:0]    new_dir_y,
	output logic [bss_pkg::CNT_W-1:0]           near_count,
	output logic [bss_pkg::CNT_W-1:0]           target_count,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bss_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bss_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import bss_pkg::*;

	cfg_t  cfg_q;
	logic  push, q_full, q_valid, pop;
	item_t push_item, head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_distance <= RST_MIN_DISTANCE;
			cfg_q.view_radius  <= RST_VIEW_RADIUS;
			cfg_q.center_gain  <= RST_CENTER_GAIN;
			cfg_q.match_gain   <= RST_MATCH_GAIN;
			cfg_q.avoid_gain   <= RST_AVOID_GAIN;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MIN_DISTANCE: cfg_q.min_distance <= cfg_data[DIST_W-1:0];
				REG_VIEW_RADIUS:  cfg_q.view_radius  <= cfg_data[DIST_W-1:0];
				REG_CENTER_GAIN:  cfg_q.center_gain  <= cfg_data[GAIN_W-1:0];
				REG_MATCH_GAIN:   cfg_q.match_gain   <= cfg_data[GAIN_W-1:0];
				REG_AVOID_GAIN:   cfg_q.avoid_gain   <= cfg_data[GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	bss_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.member_index (member_index),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.dir_x        (dir_x),
		.dir_y        (dir_y),
		.last         (last),
		.push         (push),
		.push_item    (push_item),
		.q_full       (q_full)
	);

	bss_queue #(.DEPTH(2)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_valid),
		.head      (head)
	);

	bss_back #(.MAX_FLOCK(MAX_FLOCK), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (head),
		.pop          (pop),
		.cfg          (cfg_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.new_dir_x    (new_dir_x),
		.new_dir_y    (new_dir_y),
		.near_count   (near_count),
		.target_count (target_count)
	);
endmodule
`default_nettype wire

// ===== hw/rtl/bss_checker.sv =====
// Port-level checker of the boid steering step block and its bind.
`default_nettype none
module bss_checker #(
	parameter int MAX_FLOCK = 1024
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic signed [bss_pkg::POS_W-1:0] new_dir_x,
	input logic signed [bss_pkg::POS_W-1:0] new_dir_y,
	input logic [bss_pkg::CNT_W-1:0]        near_count,
	input logic [bss_pkg::CNT_W-1:0]        target_count,
	input logic                             cfg_valid,
	input logic                             cfg_ready
);
	import bss_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(new_dir_x) && $stable(new_dir_y))
		else $error("result word changed while stalled");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> near_count <= CNT_W'(MAX_FLOCK) && target_count <= CNT_W'(MAX_FLOCK))
		else $error("tally beyond flock limit");

	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid && !in_stall)
		else $error("block not quiet after reset");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write refused");
endmodule

bind boid_steering_step_top bss_checker #(.MAX_FLOCK(MAX_FLOCK)) u_bss_checker (.*);
`default_nettype wire
